// ===== hdl/gsed_pkg.sv =====
// ----------------------------------------------------------------------------
// gsed_pkg
// Shared types, constants and helpers of the Gaussian/Sobel edge detector.
// ----------------------------------------------------------------------------
package gsed_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int CNT_W      = $clog2(MAX_DIM + 4);
  localparam int REG_DIM_W  = 11;
  localparam int THR_W      = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;
  localparam int PIX_W      = 24;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [REG_DIM_W-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [REG_DIM_W-1:0] RESET_HEIGHT = 11'd480;
  localparam logic [THR_W-1:0]     RESET_THR    = 21'd100;

  // Division by 159 as a multiply by the rounded-up reciprocal, exact for sums below 2^16.
  localparam logic [15:0] BLUR_RECIP = 16'd52759;
  localparam int          BLUR_SHIFT = 23;

  localparam logic [3:0] GAUSS_W [5][5] = '{
    '{4'd2, 4'd4, 4'd5,  4'd4, 4'd2},
    '{4'd4, 4'd9, 4'd12, 4'd9, 4'd4},
    '{4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
    '{4'd4, 4'd9, 4'd12, 4'd9, 4'd4},
    '{4'd2, 4'd4, 4'd5,  4'd4, 4'd2}
  };

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic       op;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } in_word_t;

  typedef struct packed {
    logic edge_res;
    logic last_of_frame;
  } out_word_t;

  typedef struct packed {
    logic             step;
    logic [COL_W-1:0] n_col;
    logic             b_valid;
    logic             b_border;
    logic [COL_W-1:0] b_col;
    logic             m_emit;
    logic             m_border;
    logic             m_last;
  } tag_t;

  function automatic logic [CNT_W-1:0] clamp_dim(logic [REG_DIM_W-1:0] v, int hi);
    logic [CNT_W-1:0] r;
    if (32'(v) < 3) r = CNT_W'(3);
    else if (32'(v) > hi) r = CNT_W'(hi);
    else r = CNT_W'(v);
    return r;
  endfunction

endpackage

// ===== hdl/gaussian_sobel_edge_detector_unit.sv =====
// ----------------------------------------------------------------------------
// gaussian_sobel_edge_detector_unit
// Raster-order BGR pixels in, one edge flag per pixel out, 5x5 Gaussian blur
// followed by a 3x3 Sobel test against a squared threshold.
// ----------------------------------------------------------------------------
//  channel | signals                                    | word
//  pixel   | pixel_valid, pixel_stall, pixel            | op, blue, green, red
//  result  | result_valid, result_stall, result         | edge_res, last_of_frame
//  config  | cfg_write, cfg_index, cfg_data             | register write
//
// One pixel or flush word is taken every cycle while pixel_stall is low; a
// result passes the blur and Sobel stages and the result queue before it leaves.
// Results trail their pixel by three rows and three pixels.
// Reset is synchronous; line stores need no clearing.
// pixel_stall rises when the 16-entry result queue and the pipeline hold 16
// pending results, and after the input of a three-row frame until its first result is due.
// ----------------------------------------------------------------------------
module gaussian_sobel_edge_detector_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pixel_valid,
  output logic                            pixel_stall,
  input  gsed_pkg::in_word_t              pixel,
  output logic                            result_valid,
  input  logic                            result_stall,
  output gsed_pkg::out_word_t             result,
  input  logic                            cfg_write,
  input  logic [gsed_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gsed_pkg::CFG_DATA_W-1:0] cfg_data
);

  gsed_pkg::tag_t              tag0, tag6;
  logic [gsed_pkg::PIX_W-1:0]  px0, blur6;
  logic [gsed_pkg::THR_W-1:0]  thr;
  logic                        accept, res_valid, pop, hold;
  gsed_pkg::out_word_t         res_word;
  gsed_pkg::out_word_t         fifo_mem [gsed_pkg::FIFO_DEPTH];
  logic [gsed_pkg::FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [gsed_pkg::FIFO_CNT_W-1:0] fill, occ;

  assign pixel_stall  = (occ == gsed_pkg::FIFO_CNT_W'(gsed_pkg::FIFO_DEPTH)) || hold;
  assign accept       = pixel_valid && !pixel_stall;
  assign result_valid = (fill != '0);
  assign result       = fifo_mem[rd_ptr];
  assign pop          = result_valid && !result_stall;

  gsed_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .word      (pixel),
    .tag       (tag0),
    .px        (px0),
    .thr       (thr),
    .hold      (hold)
  );

  gsed_blur u_blur (
    .clk      (clk),
    .rst      (rst),
    .tag_in   (tag0),
    .px_in    (px0),
    .tag_out  (tag6),
    .blur_out (blur6)
  );

  gsed_sobel u_sobel (
    .clk       (clk),
    .rst       (rst),
    .tag_in    (tag6),
    .blur_in   (blur6),
    .thr       (thr),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
      occ    <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr <= wr_ptr + gsed_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + gsed_pkg::FIFO_PTR_W'(1);
      end
      fill <= fill + gsed_pkg::FIFO_CNT_W'(res_valid) - gsed_pkg::FIFO_CNT_W'(pop);
      occ  <= occ + gsed_pkg::FIFO_CNT_W'(tag0.m_emit) - gsed_pkg::FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      fifo_mem[wr_ptr] <= res_word;
    end
  end

endmodule

// ===== hdl/gsed_ram.sv =====
// ----------------------------------------------------------------------------
// gsed_ram
// Simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module gsed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/gsed_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsed_ctrl
// Configuration registers and raster counters for input, blur and output.
// ----------------------------------------------------------------------------
module gsed_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [gsed_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gsed_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            accept,
  input  gsed_pkg::in_word_t              word,
  output gsed_pkg::tag_t                  tag,
  output logic [gsed_pkg::PIX_W-1:0]      px,
  output logic [gsed_pkg::THR_W-1:0]      thr,
  output logic                            hold
);

  localparam int CW = gsed_pkg::CNT_W;

  logic [gsed_pkg::REG_DIM_W-1:0] width_reg, height_reg;
  logic [CW-1:0] cur_w, cur_h;
  logic [CW-1:0] n_col, n_row, b_col, b_row, m_col, m_row;
  logic          done;
  logic          is_pixel, step, first, b_ok, m_ok, last, pad;

  always_comb begin
    is_pixel = (word.op == gsed_pkg::OP_PIXEL);
    b_ok     = (n_row > CW'(2)) || ((n_row == CW'(2)) && (n_col >= CW'(2)));
    m_ok     = (n_row > CW'(3)) || ((n_row == CW'(3)) && (n_col >= CW'(3)));
    // A three-row frame ends its input before the first result is due; the
    // counters then advance on their own until the output side catches up.
    pad      = done && !m_ok;
    hold     = pad;
    step     = pad || (accept && ((is_pixel && !done) || (!is_pixel && done)));
    first    = !done && (n_row == '0) && (n_col == '0);
    last     = (m_row == cur_h - CW'(1)) && (m_col == cur_w - CW'(1));

    tag.step     = step;
    tag.n_col    = n_col[gsed_pkg::COL_W-1:0];
    tag.b_valid  = step && b_ok;
    tag.b_border = (b_row < CW'(2)) || (b_row >= cur_h - CW'(2)) ||
                   (b_col < CW'(2)) || (b_col >= cur_w - CW'(2));
    tag.b_col    = b_col[gsed_pkg::COL_W-1:0];
    tag.m_emit   = step && m_ok;
    tag.m_border = (m_row == '0) || (m_col == '0) ||
                   (m_row >= cur_h - CW'(1)) || (m_col >= cur_w - CW'(1));
    tag.m_last   = last;

    px = is_pixel ? {word.red, word.green, word.blue} : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= gsed_pkg::RESET_WIDTH;
      height_reg <= gsed_pkg::RESET_HEIGHT;
      thr        <= gsed_pkg::RESET_THR;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gsed_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data[gsed_pkg::REG_DIM_W-1:0];
        gsed_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data[gsed_pkg::REG_DIM_W-1:0];
        gsed_pkg::REG_THRESHOLD:    thr        <= cfg_data[gsed_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_w <= gsed_pkg::clamp_dim(gsed_pkg::RESET_WIDTH, gsed_pkg::MAX_WIDTH);
      cur_h <= gsed_pkg::clamp_dim(gsed_pkg::RESET_HEIGHT, gsed_pkg::MAX_HEIGHT);
      n_col <= '0;
      n_row <= '0;
      b_col <= '0;
      b_row <= '0;
      m_col <= '0;
      m_row <= '0;
      done  <= 1'b0;
    end else if (step) begin
      if (first) begin
        cur_w <= gsed_pkg::clamp_dim(width_reg, gsed_pkg::MAX_WIDTH);
        cur_h <= gsed_pkg::clamp_dim(height_reg, gsed_pkg::MAX_HEIGHT);
      end
      if (m_ok && last) begin
        n_col <= '0;
        n_row <= '0;
        b_col <= '0;
        b_row <= '0;
        m_col <= '0;
        m_row <= '0;
        done  <= 1'b0;
      end else begin
        if (n_col == cur_w - CW'(1)) begin
          n_col <= '0;
          n_row <= n_row + CW'(1);
          if (is_pixel && (n_row == cur_h - CW'(1))) begin
            done <= 1'b1;
          end
        end else begin
          n_col <= n_col + CW'(1);
        end
        if (b_ok) begin
          if (b_col == cur_w - CW'(1)) begin
            b_col <= '0;
            b_row <= b_row + CW'(1);
          end else begin
            b_col <= b_col + CW'(1);
          end
        end
        if (m_ok) begin
          if (m_col == cur_w - CW'(1)) begin
            m_col <= '0;
            m_row <= m_row + CW'(1);
          end else begin
            m_col <= m_col + CW'(1);
          end
        end
      end
    end
  end

endmodule

// ===== hdl/gsed_blur.sv =====
// ----------------------------------------------------------------------------
// gsed_blur
// Raw line store with read-modify-write of four past rows per column, a 5x5
// window and a pipelined Gaussian blur with raw values along the border.
// ----------------------------------------------------------------------------
module gsed_blur (
  input  logic                       clk,
  input  logic                       rst,
  input  gsed_pkg::tag_t             tag_in,
  input  logic [gsed_pkg::PIX_W-1:0] px_in,
  output gsed_pkg::tag_t             tag_out,
  output logic [gsed_pkg::PIX_W-1:0] blur_out
);

  localparam int PW = gsed_pkg::PIX_W;

  gsed_pkg::tag_t t1, t2, t3, t4, t5;
  logic [PW-1:0]   px1;
  logic [4*PW-1:0] rd1;
  logic [5*PW-1:0] newcol;
  logic [5*PW-1:0] win [5];
  logic [13:0]     rsum_next [3][5];
  logic [13:0]     rsum [3][5];
  logic [15:0]     acc_next [3];
  logic [15:0]     acc [3];
  logic [31:0]     prod [3];
  logic [PW-1:0]   ctr3, ctr4, ctr5;

  gsed_ram #(.WIDTH(4*PW), .DEPTH(gsed_pkg::MAX_WIDTH)) u_raw_ram (
    .clk   (clk),
    .we    (t1.step),
    .waddr (t1.n_col),
    .wdata ({rd1[3*PW-1:0], px1}),
    .raddr (tag_in.n_col),
    .rdata (rd1)
  );

  assign newcol = {rd1, px1};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 5; i++) begin
        rsum_next[k][i] = '0;
        for (int j = 0; j < 5; j++) begin
          rsum_next[k][i] = rsum_next[k][i] +
            14'(win[j][(4-i)*PW + k*8 +: 8] * gsed_pkg::GAUSS_W[i][j]);
        end
      end
      acc_next[k] = '0;
      for (int i = 0; i < 5; i++) begin
        acc_next[k] = acc_next[k] + 16'(rsum[k][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1      <= '0;
      t2      <= '0;
      t3      <= '0;
      t4      <= '0;
      t5      <= '0;
      tag_out <= '0;
    end else begin
      t1      <= tag_in;
      t2      <= t1;
      t3      <= t2;
      t4      <= t3;
      t5      <= t4;
      tag_out <= t5;
    end
  end

  always_ff @(posedge clk) begin
    px1 <= px_in;
    if (t1.step) begin
      for (int c = 0; c < 4; c++) begin
        win[c] <= win[c+1];
      end
      win[4] <= newcol;
    end
    rsum <= rsum_next;
    ctr3 <= win[2][2*PW +: PW];
    acc  <= acc_next;
    ctr4 <= ctr3;
    for (int k = 0; k < 3; k++) begin
      prod[k] <= 32'(acc[k]) * 32'(gsed_pkg::BLUR_RECIP);
    end
    ctr5 <= ctr4;
    for (int k = 0; k < 3; k++) begin
      blur_out[k*8 +: 8] <= t5.b_border ? ctr5[k*8 +: 8] : prod[k][gsed_pkg::BLUR_SHIFT +: 8];
    end
  end

endmodule

// ===== hdl/gsed_sobel.sv =====
// ----------------------------------------------------------------------------
// gsed_sobel
// Blurred line store with read-modify-write of two past rows per column, a
// 3x3 window, Sobel gradients and the squared-magnitude threshold test.
// ----------------------------------------------------------------------------
module gsed_sobel (
  input  logic                       clk,
  input  logic                       rst,
  input  gsed_pkg::tag_t             tag_in,
  input  logic [gsed_pkg::PIX_W-1:0] blur_in,
  input  logic [gsed_pkg::THR_W-1:0] thr,
  output logic                       res_valid,
  output gsed_pkg::out_word_t        res_word
);

  localparam int PW = gsed_pkg::PIX_W;

  gsed_pkg::tag_t t7, t8, t9, t10;
  logic [PW-1:0]      blur7;
  logic [2*PW-1:0]    rd2;
  logic [3*PW-1:0]    win [3];
  logic signed [11:0] b [3][3];
  logic signed [11:0] gx_next [3];
  logic signed [11:0] gy_next [3];
  logic signed [11:0] gx [3];
  logic signed [11:0] gy [3];
  logic signed [23:0] px2 [3];
  logic signed [23:0] py2 [3];
  logic [20:0]        sqx [3];
  logic [20:0]        sqy [3];
  logic [2:0]         pass;

  gsed_ram #(.WIDTH(2*PW), .DEPTH(gsed_pkg::MAX_WIDTH)) u_blur_ram (
    .clk   (clk),
    .we    (t7.b_valid),
    .waddr (t7.b_col),
    .wdata ({rd2[PW-1:0], blur7}),
    .raddr (tag_in.b_col),
    .rdata (rd2)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          b[i][j] = signed'({4'b0, win[j][(2-i)*PW + k*8 +: 8]});
        end
      end
      gx_next[k] = b[0][2] + b[2][2] + (b[1][2] <<< 1) - b[0][0] - b[2][0] - (b[1][0] <<< 1);
      gy_next[k] = b[2][2] + b[2][0] + (b[2][1] <<< 1) - b[0][0] - b[0][2] - (b[0][1] <<< 1);
      px2[k] = gx[k] * gx[k];
      py2[k] = gy[k] * gy[k];
      pass[k] = (22'(sqx[k]) + 22'(sqy[k])) > 22'(thr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t7        <= '0;
      t8        <= '0;
      t9        <= '0;
      t10       <= '0;
      res_valid <= 1'b0;
    end else begin
      t7        <= tag_in;
      t8        <= t7;
      t9        <= t8;
      t10       <= t9;
      res_valid <= t10.m_emit;
    end
  end

  always_ff @(posedge clk) begin
    blur7 <= blur_in;
    if (t7.b_valid) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= {rd2, blur7};
    end
    gx <= gx_next;
    gy <= gy_next;
    for (int k = 0; k < 3; k++) begin
      sqx[k] <= px2[k][20:0];
      sqy[k] <= py2[k][20:0];
    end
    res_word.edge_res      <= !t10.m_border && (&pass);
    res_word.last_of_frame <= t10.m_last;
  end

endmodule
